// ===== hw/rtl/utf8d_pkg.sv =====
// Package for the UTF-8 stream decoder: field widths, byte-class masks and
// the step result type shared by the decode core and the top level.
// No dependencies.
`default_nettype none

package utf8d_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CP_W      = 21;
   localparam int unsigned PENDING_W = 2;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

   localparam logic [BYTE_W-1:0] MASK_ASCII = 8'h80;
   localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
   localparam logic [BYTE_W-1:0] TAG_LEAD2  = 8'hC0;
   localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
   localparam logic [BYTE_W-1:0] TAG_LEAD3  = 8'hE0;
   localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
   localparam logic [BYTE_W-1:0] TAG_LEAD4  = 8'hF0;
   localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
   localparam logic [BYTE_W-1:0] TAG_CONT   = 8'h80;

   localparam logic [PENDING_W-1:0] PEND_NONE  = 2'd0;
   localparam logic [PENDING_W-1:0] PEND_ONE   = 2'd1;
   localparam logic [PENDING_W-1:0] PEND_TWO   = 2'd2;
   localparam logic [PENDING_W-1:0] PEND_THREE = 2'd3;

   typedef struct packed {
      logic            emit;
      logic [CP_W-1:0] code_point;
   } step_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8d_core.sv =====
// Decode core: holds the pending count and partial code point and decodes
// one byte or end marker per step. Depends on utf8d_pkg.
`default_nettype none

module utf8d_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step_en,
   input  wire logic [utf8d_pkg::BYTE_W-1:0]  data_byte,
   input  wire logic                          end_of_stream,
   output utf8d_pkg::step_result_type         result
);
   import utf8d_pkg::*;

   logic [PENDING_W-1:0] pending_ff, pending_in;
   logic [CP_W-1:0]      partial_ff, partial_in;
   logic [CP_W-1:0]      shifted;

   assign shifted = {partial_ff[CP_W-7:0], data_byte[5:0]};

   always_comb begin
      pending_in        = pending_ff;
      partial_in        = partial_ff;
      result.emit       = 1'b0;
      result.code_point = REPLACEMENT_CP;
      if (end_of_stream) begin
         result.emit = (pending_ff != PEND_NONE);
         pending_in  = PEND_NONE;
         partial_in  = '0;
      end else if (pending_ff == PEND_NONE) begin
         if ((data_byte & MASK_ASCII) == '0) begin
            result.emit       = 1'b1;
            result.code_point = {{(CP_W-BYTE_W){1'b0}}, data_byte};
         end else if ((data_byte & MASK_LEAD2) == TAG_LEAD2) begin
            pending_in = PEND_ONE;
            partial_in = {{(CP_W-5){1'b0}}, data_byte[4:0]};
         end else if ((data_byte & MASK_LEAD3) == TAG_LEAD3) begin
            pending_in = PEND_TWO;
            partial_in = {{(CP_W-4){1'b0}}, data_byte[3:0]};
         end else if ((data_byte & MASK_LEAD4) == TAG_LEAD4) begin
            pending_in = PEND_THREE;
            partial_in = {{(CP_W-3){1'b0}}, data_byte[2:0]};
         end else begin
            result.emit = 1'b1;
         end
      end else if ((data_byte & MASK_CONT) != TAG_CONT) begin
         result.emit = 1'b1;
         pending_in  = PEND_NONE;
         partial_in  = '0;
      end else begin
         pending_in = pending_ff - PEND_ONE;
         if (pending_ff == PEND_ONE) begin
            result.emit       = 1'b1;
            result.code_point = shifted;
            partial_in        = '0;
         end else begin
            partial_in = shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         partial_ff <= '0;
      end else if (step_en) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder top level: input register, decode core, result register.
// An item's code point passes from the input register through the decode core into the result register, then rsp_.
// Throughput: one item per cycle; an item that yields a code point waits in the
// input register only while the result register holds an item that is not taken.
// Reset clears both stages and the decoder state. Depends on utf8d_pkg and utf8d_core.
`default_nettype none

module utf8_stream_decoder_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [utf8d_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic                         req_end_of_stream,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [utf8d_pkg::CP_W-1:0]        rsp_code_point
);
   import utf8d_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eos_ff;
   logic              out_valid_ff, out_valid_in;
   logic [CP_W-1:0]   out_cp_ff;
   logic              out_free;
   logic              step_en;
   step_result_type   step;

   utf8d_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .data_byte     (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .result        (step)
   );

   assign out_free    = !out_valid_ff || rsp_ready;
   assign step_en     = in_valid_ff && (out_free || !step.emit);
   assign req_ready   = !in_valid_ff || step_en;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step_en);
   assign out_valid_in = (step_en && step.emit) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_stream;
      end
      if (step_en && step.emit) begin
         out_cp_ff <= step.code_point;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !req_ready |-> out_valid_ff && !rsp_ready)
      else $error("Input stage stalled while the result register could take an item.");

   assert property (@(posedge clock) disable iff (reset)
      step_en && in_eos_ff && step.emit |-> step.code_point == REPLACEMENT_CP)
      else $error("End of stream produced a code point other than the replacement.");

   assert property (@(posedge clock) disable iff (reset)
      step_en && step.emit |=> rsp_valid && rsp_code_point == $past(step.code_point))
      else $error("Decoded code point did not reach the result register.");

endmodule

`default_nettype wire

// ===== tb/utf8_decode_checker.sv =====
`timescale 1ns / 1ps
// Checker for the UTF-8 stream decoder: watches both handshakes, predicts the
// decoded code points and compares them in order. Depends on utf8d_pkg.

module utf8_decode_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [utf8d_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                         req_end_of_stream,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [utf8d_pkg::CP_W-1:0]   rsp_code_point,
   output int                           fail_count,
   output int                           expected_count,
   output int                           accepted_items,
   output int                           checked_results,
   output int                           replacement_results
);
   import utf8d_pkg::*;

   logic [PENDING_W-1:0] seq_left;
   logic [CP_W-1:0]      seq_value;
   logic [CP_W-1:0]      decoded_q[$];
   int                   mismatches;
   int                   items_seen;
   int                   results_seen;
   int                   replacements_seen;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   function automatic void decode_byte_step(input logic [BYTE_W-1:0] b, input logic eos,
                                            output logic emits, output logic [CP_W-1:0] cp);
      emits = 1'b0;
      cp = '0;
      if (eos) begin
         if (seq_left != PEND_NONE) begin
            seq_left = PEND_NONE;
            seq_value = '0;
            emits = 1'b1;
            cp = REPLACEMENT_CP;
         end
      end else if (seq_left == PEND_NONE) begin
         if ((b & MASK_ASCII) == '0) begin
            emits = 1'b1;
            cp = CP_W'(b);
         end else if ((b & MASK_LEAD2) == TAG_LEAD2) begin
            seq_value = CP_W'(b[4:0]);
            seq_left = PEND_ONE;
         end else if ((b & MASK_LEAD3) == TAG_LEAD3) begin
            seq_value = CP_W'(b[3:0]);
            seq_left = PEND_TWO;
         end else if ((b & MASK_LEAD4) == TAG_LEAD4) begin
            seq_value = CP_W'(b[2:0]);
            seq_left = PEND_THREE;
         end else begin
            emits = 1'b1;
            cp = REPLACEMENT_CP;
         end
      end else if ((b & MASK_CONT) != TAG_CONT) begin
         seq_left = PEND_NONE;
         seq_value = '0;
         emits = 1'b1;
         cp = REPLACEMENT_CP;
      end else begin
         seq_value = {seq_value[CP_W-7:0], b[5:0]};
         seq_left = seq_left - 1'b1;
         if (seq_left == PEND_NONE) begin
            emits = 1'b1;
            cp = seq_value;
            seq_value = '0;
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      logic            emits;
      logic [CP_W-1:0] cp;
      logic [CP_W-1:0] want;
      if (reset) begin
         seq_left = PEND_NONE;
         seq_value = '0;
         decoded_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("code point %h with nothing expected", rsp_code_point));
            end else begin
               want = decoded_q.pop_front();
               results_seen++;
               if (want == REPLACEMENT_CP) begin
                  replacements_seen++;
               end
               if (rsp_code_point !== want) begin
                  report_mismatch($sformatf("code point %h, expected %h", rsp_code_point, want));
               end
            end
         end
         if (req_valid && req_ready) begin
            items_seen++;
            decode_byte_step(req_data_byte, req_end_of_stream, emits, cp);
            if (emits) begin
               decoded_q.push_back(cp);
            end
         end
      end
      fail_count <= mismatches;
      expected_count <= decoded_q.size();
      accepted_items <= items_seen;
      checked_results <= results_seen;
      replacement_results <= replacements_seen;
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus and
// receiver stalls, and the verdict. Depends on utf8d_pkg, the decoder and the checker.

module tb;
   import utf8d_pkg::*;

   localparam int TOTAL_ITEMS   = 1650;
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [8:0] EOS_MARK = 9'h100;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte;
   logic              req_end_of_stream;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [CP_W-1:0]   rsp_code_point;

   int  fail_count;
   int  expected_count;
   int  accepted_items;
   int  checked_results;
   int  replacement_results;
   int  bytes_sent;
   bit  quiet_idle;
   bit  hold_off_req;
   bit  drain_timeout;

   logic [8:0] directed_items[24] = '{
      9'h000, 9'h07F, 9'h080, 9'h0FF, 9'h0F8,
      9'h0C2, 9'h0A9,
      9'h0E2, 9'h082, 9'h0AC,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h0DF, 9'h0BF,
      9'h0E2, 9'h041,
      9'h0F0, 9'h090, EOS_MARK,
      EOS_MARK | 9'h0FF,
      9'h0C0, 9'h0C3
   };

   utf8_stream_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_point    (rsp_code_point)
   );

   utf8_decode_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_code_point      (rsp_code_point),
      .fail_count          (fail_count),
      .expected_count      (expected_count),
      .accepted_items      (accepted_items),
      .checked_results     (checked_results),
      .replacement_results (replacement_results)
   );

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Run limit reached with %0d code points outstanding.", expected_count);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (!quiet_idle && $urandom_range(0, 99) < 27) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic eos);
      if (!quiet_idle && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (expected_count != 0 && waited < DRAIN_LIMIT);
      if (expected_count != 0) begin
         drain_timeout = 1'b1;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] lead_byte(input int len);
      logic [BYTE_W-1:0] r;
      r = BYTE_W'($urandom);
      case (len)
         1: lead_byte = {1'b0, r[6:0]};
         2: lead_byte = {3'b110, r[4:0]};
         3: lead_byte = {4'b1110, r[3:0]};
         default: lead_byte = {5'b11110, r[2:0]};
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] continuation_byte();
      logic [BYTE_W-1:0] r;
      r = BYTE_W'($urandom);
      continuation_byte = {2'b10, r[5:0]};
   endfunction

   task automatic send_code_point(input int len);
      send_item(lead_byte(len), 1'b0);
      for (int i = 1; i < len; i++) begin
         send_item(continuation_byte(), 1'b0);
      end
   endtask

   task automatic send_broken_sequence();
      int                len;
      int                kept;
      logic [BYTE_W-1:0] intruder;
      len = $urandom_range(2, 4);
      kept = $urandom_range(0, len - 2);
      send_item(lead_byte(len), 1'b0);
      for (int i = 0; i < kept; i++) begin
         send_item(continuation_byte(), 1'b0);
      end
      if ($urandom_range(0, 2) == 0) begin
         send_item(BYTE_W'($urandom), 1'b1);
      end else begin
         intruder = BYTE_W'($urandom);
         if (intruder[7:6] == 2'b10) begin
            intruder[6] = 1'b1;
         end
         send_item(intruder, 1'b0);
      end
   endtask

   task automatic run_random_phase(input int stop_at);
      int pick;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_code_point($urandom_range(1, 4));
         end else if (pick < 85) begin
            send_broken_sequence();
         end else if (pick < 95) begin
            send_item(BYTE_W'($urandom), 1'b0);
         end else begin
            send_item(BYTE_W'($urandom), 1'b1);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_end_of_stream = 1'b0;
      bytes_sent = 0;
      quiet_idle = 1'b0;
      hold_off_req = 1'b0;
      drain_timeout = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_items[i]) begin
         send_item(directed_items[i][7:0], directed_items[i][8]);
      end
      drain_results();

      run_random_phase(bytes_sent + 400);
      drain_results();

      quiet_idle = 1'b1;
      run_random_phase(bytes_sent + 400);
      drain_results();
      quiet_idle = 1'b0;

      hold_off_req = 1'b1;
      run_random_phase(bytes_sent + 400);
      drain_results();

      run_random_phase(TOTAL_ITEMS);
      drain_results();

      $display("Sent %0d items, %0d directed, through idle, stall and hold-off phases.",
               accepted_items, $size(directed_items));
      $display("Checked %0d code points, %0d of them replacement characters; %0d mismatches.",
               checked_results, replacement_results, fail_count);
      if (fail_count == 0 && expected_count == 0 && !drain_timeout) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
